>>> src/pte_pkg.sv
// shared types, constants and helper functions for the palette tint and fade engine
package pte_pkg;

   localparam int COMP_W        = 6;
   localparam int VALUE_W       = 9;
   localparam int LEVEL_W       = 7;
   localparam int KIND_W        = 4;
   localparam int INDEX_W       = 8;
   localparam int DELTA_W       = 8;
   localparam int GAMMA_W       = 4;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 4;
   localparam int WIDE_W        = 10;

   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam wide_type COMPONENT_MAX = 10'sd63;
   localparam wide_type LEVEL_LIMIT   = 10'sd63;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE      = 4'd0,
      KIND_READ_RAW   = 4'd1,
      KIND_READ_ADJ   = 4'd2,
      KIND_ADD_TINT   = 4'd3,
      KIND_SET_TINT   = 4'd4,
      KIND_ADD_FILTER = 4'd5,
      KIND_SET_FILTER = 4'd6,
      KIND_CLR_FILTER = 4'd7,
      KIND_TICK       = 4'd8,
      KIND_FADE       = 4'd9
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FADE
   } state_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA_OFFSET   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EFFECTS_ENABLE = 1'b1;

   typedef struct packed {
      logic                accept;
      kind_type            kind;
      logic                adjust;
      logic [GAMMA_W-1:0]  gamma;
   } lane_ctrl_type;

   function automatic logic [COMP_W-1:0] clamp_comp(input wide_type v);
      logic [COMP_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > COMPONENT_MAX) begin
         r = COMPONENT_MAX[COMP_W-1:0];
      end else begin
         r = v[COMP_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [LEVEL_W-1:0] clamp_level(input wide_type v);
      logic signed [LEVEL_W-1:0] r;
      if (v < -LEVEL_LIMIT) begin
         r = $signed(-LEVEL_LIMIT[LEVEL_W-1:0]);
      end else if (v > LEVEL_LIMIT) begin
         r = $signed(LEVEL_LIMIT[LEVEL_W-1:0]);
      end else begin
         r = $signed(v[LEVEL_W-1:0]);
      end
      return r;
   endfunction

endpackage

>>> src/pte_if.sv
// request and response channel interfaces
interface pte_req_if;
   import pte_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          kind;
   logic [INDEX_W-1:0]         index;
   logic signed [VALUE_W-1:0]  red_value;
   logic signed [VALUE_W-1:0]  green_value;
   logic signed [VALUE_W-1:0]  blue_value;
   logic [DELTA_W-1:0]         delta;

   modport source (output valid, kind, index, red_value, green_value, blue_value, delta,
                   input ready);
   modport sink (input valid, kind, index, red_value, green_value, blue_value, delta,
                 output ready);
endinterface

interface pte_rsp_if;
   import pte_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [INDEX_W-1:0]   entry_number;
   logic [COMP_W-1:0]    out_red;
   logic [COMP_W-1:0]    out_green;
   logic [COMP_W-1:0]    out_blue;

   modport source (output valid, entry_number, out_red, out_green, out_blue, input ready);
   modport sink (input valid, entry_number, out_red, out_green, out_blue, output ready);
endinterface

>>> src/pte_lane.sv
// one color channel: tint, filter, fade target and the per-component arithmetic
module pte_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  pte_pkg::lane_ctrl_type              ctrl,
   input  logic signed [pte_pkg::VALUE_W-1:0]  value,
   input  logic [pte_pkg::DELTA_W-1:0]         delta,
   input  logic [pte_pkg::COMP_W-1:0]          raw_comp,
   output logic [pte_pkg::COMP_W-1:0]          write_comp,
   output logic [pte_pkg::COMP_W-1:0]          fade_comp,
   output logic [pte_pkg::COMP_W-1:0]          read_comp
);
   import pte_pkg::*;

   logic signed [LEVEL_W-1:0] tint_ff, tint_in;
   logic signed [LEVEL_W-1:0] filter_ff, filter_in;
   logic [COMP_W-1:0]         target_ff, target_in;

   wide_type value_w, tint_w, filter_w, delta_w, raw_w, target_w;
   wide_type decay_sum, adj_sum, fade_diff;
   logic signed [LEVEL_W-1:0] tint_decayed;

   always_comb begin
      value_w  = WIDE_W'(value);
      tint_w   = WIDE_W'(tint_ff);
      filter_w = WIDE_W'(filter_ff);
      delta_w  = $signed({2'b00, delta});
      raw_w    = $signed({4'b0000, raw_comp});
      target_w = $signed({4'b0000, target_ff});
   end

   // tint moves toward zero and stops there
   always_comb begin
      decay_sum    = '0;
      tint_decayed = tint_ff;
      if (tint_w < 0) begin
         decay_sum    = tint_w + delta_w;
         tint_decayed = (decay_sum > 0) ? '0 : $signed(decay_sum[LEVEL_W-1:0]);
      end else if (tint_w > 0) begin
         decay_sum    = tint_w - delta_w;
         tint_decayed = (decay_sum < 0) ? '0 : $signed(decay_sum[LEVEL_W-1:0]);
      end
   end

   always_comb begin
      tint_in   = tint_ff;
      filter_in = filter_ff;
      target_in = target_ff;
      if (ctrl.accept) begin
         case (ctrl.kind)
            KIND_ADD_TINT:   tint_in   = clamp_level(tint_w + value_w);
            KIND_SET_TINT:   tint_in   = clamp_level(value_w);
            KIND_TICK:       tint_in   = tint_decayed;
            KIND_ADD_FILTER: filter_in = clamp_level(filter_w + value_w);
            KIND_SET_FILTER: filter_in = clamp_level(value_w);
            KIND_CLR_FILTER: filter_in = '0;
            KIND_FADE:       target_in = clamp_comp(value_w);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      write_comp = clamp_comp(value_w);
      adj_sum    = raw_w + tint_w + filter_w + $signed({6'b000000, ctrl.gamma});
      read_comp  = ctrl.adjust ? clamp_comp(adj_sum) : raw_comp;
      // two unit steps toward the target in one go
      fade_diff  = target_w - raw_w;
      if (fade_diff >= 2) begin
         fade_comp = raw_comp + COMP_W'(2);
      end else if (fade_diff <= -2) begin
         fade_comp = raw_comp - COMP_W'(2);
      end else begin
         fade_comp = target_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_ff   <= '0;
         filter_ff <= '0;
      end else begin
         tint_ff   <= tint_in;
         filter_ff <= filter_in;
      end
      target_ff <= target_in;
   end

endmodule

>>> src/palette_tint_fade_engine_top.sv
// top level: palette memory, sequencer, three channel lanes and the response merge
//
//   channel   dir  handshake           carries
//   req_chan  in   valid / ready       kind, index, red/green/blue value, delta
//   rsp_chan  out  valid / ready       entry_number, out_red, out_green, out_blue
//   csr_*     in   csr_write_enable    csr_index, csr_write_data
//
// a read first registers the palette entry, then adjusts it and loads the response register
// once that register is free. writes, tint and filter updates and ticks are registered as accepted.
// a fade pass walks the palette one entry per cycle through the memory port.
// synchronous reset clears tint, filter, gamma, control, sets effects enable, not palette.
// a read stalls the request channel until the response register is free to take its result;
// while an earlier response waits, other requests are still taken.
module palette_tint_fade_engine_top #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   pte_req_if.sink                               req_chan,
   pte_rsp_if.source                             rsp_chan,
   input  logic                                  csr_write_enable,
   input  logic [pte_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pte_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   import pte_pkg::*;

   localparam int ADDR_W  = $clog2(PALETTE_ENTRIES);
   localparam int ENTRY_W = 3 * COMP_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);

   state_type state_ff, state_in;

   logic [GAMMA_W-1:0] gamma_ff, gamma_in;
   logic               effects_ff, effects_in;

   logic [ENTRY_W-1:0] palette_mem [PALETTE_ENTRIES];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               mem_re, mem_we;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic [ADDR_W-1:0]  fade_addr_ff, fade_addr_in;
   logic [INDEX_W-1:0] rd_index_ff, rd_index_in;
   logic               rd_adjust_ff, rd_adjust_in;
   logic               rd_inrange_ff, rd_inrange_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_entry_ff, rsp_entry_in;
   logic [COMP_W-1:0]  rsp_red_ff, rsp_red_in;
   logic [COMP_W-1:0]  rsp_green_ff, rsp_green_in;
   logic [COMP_W-1:0]  rsp_blue_ff, rsp_blue_in;

   logic               accept;
   logic               out_free;
   logic               index_ok;
   kind_type           req_kind;
   logic [ADDR_W-1:0]  req_addr;
   lane_ctrl_type      lane_ctrl;

   logic signed [VALUE_W-1:0] lane_value [3];
   logic [COMP_W-1:0]         lane_write [3];
   logic [COMP_W-1:0]         lane_fade  [3];
   logic [COMP_W-1:0]         lane_read  [3];

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_kind = kind_type'(req_chan.kind);
   assign req_addr = ADDR_W'(req_chan.index);
   assign index_ok = 32'(req_chan.index) < 32'(PALETTE_ENTRIES);

   assign lane_value[0] = req_chan.red_value;
   assign lane_value[1] = req_chan.green_value;
   assign lane_value[2] = req_chan.blue_value;

   assign lane_ctrl.accept = accept;
   assign lane_ctrl.kind   = req_kind;
   assign lane_ctrl.adjust = rd_adjust_ff;
   assign lane_ctrl.gamma  = gamma_ff;

   for (genvar c = 0; c < 3; c++) begin : g_lane
      pte_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .value      (lane_value[c]),
         .delta      (req_chan.delta),
         .raw_comp   (rd_data_ff[c*COMP_W +: COMP_W]),
         .write_comp (lane_write[c]),
         .fade_comp  (lane_fade[c]),
         .read_comp  (lane_read[c])
      );
   end

   // configuration registers
   always_comb begin
      gamma_in   = gamma_ff;
      effects_in = effects_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_GAMMA_OFFSET:   gamma_in   = csr_write_data;
            CSR_EFFECTS_ENABLE: effects_in = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind inside {KIND_READ_RAW, KIND_READ_ADJ})) begin
               state_in = ST_READ;
            end else if (accept && req_kind == KIND_FADE) begin
               state_in = ST_FADE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FADE: begin
            if (fade_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs, memory control and response merge
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      mem_re         = 1'b0;
      mem_we         = 1'b0;
      rd_addr        = req_addr;
      wr_addr        = req_addr;
      wr_data        = {lane_write[2], lane_write[1], lane_write[0]};
      fade_addr_in   = fade_addr_ff;
      rd_index_in    = rd_index_ff;
      rd_adjust_in   = rd_adjust_ff;
      rd_inrange_in  = rd_inrange_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_entry_in   = rsp_entry_ff;
      rsp_red_in     = rsp_red_ff;
      rsp_green_in   = rsp_green_ff;
      rsp_blue_in    = rsp_blue_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_WRITE: mem_we = index_ok;
                  KIND_READ_RAW, KIND_READ_ADJ: begin
                     mem_re        = index_ok;
                     rd_index_in   = req_chan.index;
                     rd_adjust_in  = (req_kind == KIND_READ_ADJ) && effects_ff;
                     rd_inrange_in = index_ok;
                  end
                  KIND_FADE: begin
                     mem_re       = 1'b1;
                     rd_addr      = '0;
                     fade_addr_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = rd_index_ff;
               rsp_red_in   = rd_inrange_ff ? lane_read[0] : '0;
               rsp_green_in = rd_inrange_ff ? lane_read[1] : '0;
               rsp_blue_in  = rd_inrange_ff ? lane_read[2] : '0;
            end
         end
         ST_FADE: begin
            // write back entry n while entry n+1 is read
            mem_we  = 1'b1;
            wr_addr = fade_addr_ff;
            wr_data = {lane_fade[2], lane_fade[1], lane_fade[0]};
            if (fade_addr_ff != LAST_ADDR) begin
               mem_re       = 1'b1;
               rd_addr      = fade_addr_ff + 1'b1;
               fade_addr_in = fade_addr_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.entry_number = rsp_entry_ff;
   assign rsp_chan.out_red      = rsp_red_ff;
   assign rsp_chan.out_green    = rsp_green_ff;
   assign rsp_chan.out_blue     = rsp_blue_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= palette_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gamma_ff     <= '0;
         effects_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gamma_ff     <= gamma_in;
         effects_ff   <= effects_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fade_addr_ff  <= fade_addr_in;
      rd_index_ff   <= rd_index_in;
      rd_adjust_ff  <= rd_adjust_in;
      rd_inrange_ff <= rd_inrange_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_red_ff    <= rsp_red_in;
      rsp_green_ff  <= rsp_green_in;
      rsp_blue_ff   <= rsp_blue_in;
   end

   a_read_enters_read: assert property (@(posedge clock) disable iff (reset)
      accept && (req_kind == KIND_READ_RAW || req_kind == KIND_READ_ADJ)
      |=> state_ff == ST_READ)
      else $error("read request did not enter the read state");

   a_fade_walks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FADE && fade_addr_ff != LAST_ADDR
      |=> state_ff == ST_FADE && fade_addr_ff == $past(fade_addr_ff) + 1'b1)
      else $error("fade pass skipped or ended early");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_READ)
      else $error("response appeared without a read");

   a_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !mem_we)
      else $error("palette written while a read is pending");

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for the palette tint and fade engine
`timescale 1ns / 100ps

module tb_top;
   import pte_pkg::*;

   localparam int ENTRIES       = 256;
   localparam int COMP_TOP      = 63;
   localparam int LEVEL_MAX     = 63;
   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 228;

   localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 4'd10;
   localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 4'd15;

   typedef struct {
      logic [KIND_W-1:0]         kind;
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] red;
      logic signed [VALUE_W-1:0] green;
      logic signed [VALUE_W-1:0] blue;
      logic [DELTA_W-1:0]        delta;
   } color_request_type;

   typedef struct packed {
      logic [INDEX_W-1:0] entry;
      logic [COMP_W-1:0]  red;
      logic [COMP_W-1:0]  green;
      logic [COMP_W-1:0]  blue;
   } color_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   pte_req_if req_if ();
   pte_rsp_if rsp_if ();

   palette_tint_fade_engine_top #(
      .PALETTE_ENTRIES(ENTRIES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow copy of the engine state
   logic [COMP_W-1:0]         shadow_palette [ENTRIES][3];
   logic signed [LEVEL_W-1:0] tint_now [3];
   logic signed [LEVEL_W-1:0] filter_now [3];
   logic [GAMMA_W-1:0]        gamma_now;
   logic                      effects_now;

   color_request_type pending_requests [$];
   color_reply_type   expected_colors [$];
   color_request_type in_flight;
   bit             entry_known [ENTRIES];
   int             known_list [$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             gap_left = 0;
   int             stall_left = 0;
   bit             no_gaps = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int clip(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int any_value();
      return int'($urandom_range(0, 511)) - 256;
   endfunction

   function automatic int near_zero(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // applies one accepted request to the shadow state, queues the color it reads back
   function automatic void track_palette_request(color_request_type rq);
      int amount [3];
      int target [3];
      int level;
      int d;
      int ch;
      int e;
      int s;
      logic [COMP_W-1:0] shade [3];
      color_reply_type reply;
      amount[0] = int'($signed(rq.red));
      amount[1] = int'($signed(rq.green));
      amount[2] = int'($signed(rq.blue));
      d = int'(rq.delta);
      case (rq.kind)
         KIND_WRITE: begin
            for (ch = 0; ch < 3; ch++)
               shadow_palette[rq.index][ch] = COMP_W'(clip(amount[ch], 0, COMP_TOP));
         end
         KIND_READ_RAW, KIND_READ_ADJ: begin
            for (ch = 0; ch < 3; ch++) begin
               level = int'(shadow_palette[rq.index][ch]);
               if (rq.kind == KIND_READ_ADJ && effects_now)
                  level = level + int'(tint_now[ch]) + int'(filter_now[ch]) + int'(gamma_now);
               shade[ch] = COMP_W'(clip(level, 0, COMP_TOP));
            end
            reply.entry = rq.index;
            reply.red   = shade[0];
            reply.green = shade[1];
            reply.blue  = shade[2];
            expected_colors.push_back(reply);
         end
         KIND_ADD_TINT: begin
            for (ch = 0; ch < 3; ch++)
               tint_now[ch] = LEVEL_W'(clip(int'(tint_now[ch]) + amount[ch],
                                            -LEVEL_MAX, LEVEL_MAX));
         end
         KIND_SET_TINT: begin
            for (ch = 0; ch < 3; ch++)
               tint_now[ch] = LEVEL_W'(clip(amount[ch], -LEVEL_MAX, LEVEL_MAX));
         end
         KIND_ADD_FILTER: begin
            for (ch = 0; ch < 3; ch++)
               filter_now[ch] = LEVEL_W'(clip(int'(filter_now[ch]) + amount[ch],
                                              -LEVEL_MAX, LEVEL_MAX));
         end
         KIND_SET_FILTER: begin
            for (ch = 0; ch < 3; ch++)
               filter_now[ch] = LEVEL_W'(clip(amount[ch], -LEVEL_MAX, LEVEL_MAX));
         end
         KIND_CLR_FILTER: begin
            for (ch = 0; ch < 3; ch++)
               filter_now[ch] = '0;
         end
         KIND_TICK: begin
            // decay toward zero, never past it
            for (ch = 0; ch < 3; ch++) begin
               level = int'(tint_now[ch]);
               if (level < 0)
                  level = (level + d > 0) ? 0 : level + d;
               else if (level > 0)
                  level = (level - d < 0) ? 0 : level - d;
               tint_now[ch] = LEVEL_W'(level);
            end
         end
         KIND_FADE: begin
            for (ch = 0; ch < 3; ch++)
               target[ch] = clip(amount[ch], 0, COMP_TOP);
            for (e = 0; e < ENTRIES; e++) begin
               for (ch = 0; ch < 3; ch++) begin
                  level = int'(shadow_palette[e][ch]);
                  for (s = 0; s < 2; s++) begin
                     if (level < target[ch])
                        level++;
                     else if (level > target[ch])
                        level--;
                  end
                  shadow_palette[e][ch] = COMP_W'(level);
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void queue_request(input logic [KIND_W-1:0] kind, input int index,
                                         input int red, input int green, input int blue,
                                         input int delta);
      color_request_type rq;
      rq.kind  = kind;
      rq.index = INDEX_W'(index);
      rq.red   = VALUE_W'(red);
      rq.green = VALUE_W'(green);
      rq.blue  = VALUE_W'(blue);
      rq.delta = DELTA_W'(delta);
      if (kind == KIND_WRITE && !entry_known[rq.index]) begin
         entry_known[rq.index] = 1'b1;
         known_list.push_back(int'(rq.index));
      end
      pending_requests.push_back(rq);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] which,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= which;
      csr_write_data   <= data;
      if (which == CSR_GAMMA_OFFSET)
         gamma_now = GAMMA_W'(data);
      else
         effects_now = data[0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // a fade pass gives no response, so let it finish before touching registers
   task automatic wait_for_drain();
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_if.valid || expected_colors.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : request_drive
      color_request_type queued;
      logic busy;
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else begin
         busy = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            track_palette_request(in_flight);
            busy = 1'b0;
         end
         if (!busy) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() != 0) begin
               queued = pending_requests.pop_front();
               in_flight = queued;
               req_if.kind        <= queued.kind;
               req_if.index       <= queued.index;
               req_if.red_value   <= queued.red;
               req_if.green_value <= queued.green;
               req_if.blue_value  <= queued.blue;
               req_if.delta       <= queued.delta;
               busy = 1'b1;
               gap_left = no_gaps ? 0 : int'($urandom_range(0, 4));
            end
         end
         req_if.valid <= busy;
      end
   end

   always @(posedge clock) begin : response_check
      color_reply_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_colors.size() == 0) begin
               $error("response for entry %0d with no read request pending",
                      rsp_if.entry_number);
               error_count++;
            end else begin
               want = expected_colors.pop_front();
               check_field("entry_number", want.entry, rsp_if.entry_number);
               check_field("out_red", want.red, rsp_if.out_red);
               check_field("out_green", want.green, rsp_if.out_green);
               check_field("out_blue", want.blue, rsp_if.out_blue);
            end
            stall_left = no_gaps ? 0 : int'($urandom_range(0, 4));
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[palette_tint_fade_engine_top] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int ph;
      int n;
      int e;
      int roll;
      int idx;
      int vr;
      int vg;
      int vb;
      int dl;
      logic [GAMMA_W-1:0] gamma_pick;
      logic               enable_pick;

      req_if.valid       = 1'b0;
      req_if.kind        = '0;
      req_if.index       = '0;
      req_if.red_value   = '0;
      req_if.green_value = '0;
      req_if.blue_value  = '0;
      req_if.delta       = '0;
      rsp_if.ready       = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = '0;
      csr_write_data     = '0;
      for (e = 0; e < ENTRIES; e++) begin
         shadow_palette[e][0] = '0;
         shadow_palette[e][1] = '0;
         shadow_palette[e][2] = '0;
      end
      for (e = 0; e < 3; e++) begin
         tint_now[e]   = '0;
         filter_now[e] = '0;
      end
      gamma_now   = '0;
      effects_now = 1'b1;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: clamping at both ends, saturation, decay, unused kinds, fade
      queue_request(KIND_WRITE, 0, -255, 0, 255, 0);
      queue_request(KIND_WRITE, 255, 63, 64, -1, 255);
      queue_request(KIND_WRITE, 128, 30, -256, 100, 0);
      queue_request(KIND_READ_RAW, 0, 0, 0, 0, 0);
      queue_request(KIND_READ_RAW, 255, 255, -255, -256, 255);
      queue_request(KIND_SET_TINT, 0, 63, -63, 255, 0);
      queue_request(KIND_READ_ADJ, 128, 0, 0, 0, 0);
      queue_request(KIND_ADD_TINT, 0, 255, -255, 1, 0);
      queue_request(KIND_SET_FILTER, 0, -255, 20, 0, 0);
      queue_request(KIND_ADD_FILTER, 0, 100, -100, -256, 0);
      queue_request(KIND_READ_ADJ, 0, 0, 0, 0, 0);
      queue_request(KIND_READ_ADJ, 255, 0, 0, 0, 0);
      queue_request(KIND_TICK, 0, 0, 0, 0, 0);
      queue_request(KIND_TICK, 0, 0, 0, 0, 10);
      queue_request(KIND_READ_ADJ, 128, 0, 0, 0, 0);
      queue_request(KIND_TICK, 0, 0, 0, 0, 255);
      queue_request(KIND_READ_ADJ, 128, 0, 0, 0, 0);
      queue_request(KIND_CLR_FILTER, 0, 0, 0, 0, 0);
      queue_request(KIND_READ_ADJ, 0, 0, 0, 0, 0);
      queue_request(KIND_SPARE_FIRST, 5, 10, 10, 10, 3);
      queue_request(KIND_SPARE_LAST, 255, -1, -1, -1, 255);
      queue_request(KIND_FADE, 0, 255, -5, 32, 0);
      queue_request(KIND_READ_RAW, 0, 0, 0, 0, 0);
      queue_request(KIND_READ_RAW, 255, 0, 0, 0, 0);
      queue_request(KIND_READ_RAW, 128, 0, 0, 0, 0);
      wait_for_drain();

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin gamma_pick = 4'd14; enable_pick = 1'b1; end
            1: begin gamma_pick = 4'd0;  enable_pick = 1'b0; end
            2: begin gamma_pick = 4'd15; enable_pick = 1'b1; end
            3: begin gamma_pick = 4'd6;  enable_pick = 1'b1; end
            4: begin gamma_pick = GAMMA_W'(2 * $urandom_range(0, 7)); enable_pick = 1'b1; end
            5: begin gamma_pick = GAMMA_W'($urandom_range(0, 15)); enable_pick = 1'b0; end
            default: begin
               gamma_pick  = GAMMA_W'($urandom_range(0, 15));
               enable_pick = 1'($urandom_range(0, 1));
            end
         endcase
         write_csr(CSR_GAMMA_OFFSET, CSR_DATA_W'(gamma_pick));
         write_csr(CSR_EFFECTS_ENABLE, CSR_DATA_W'(enable_pick));
         // one phase runs back to back with no idling on either side
         no_gaps = (ph == 3);

         for (n = 0; n < PHASE_ITEMS; n++) begin
            roll = int'($urandom_range(0, 99));
            idx  = int'($urandom_range(0, 255));
            vr   = any_value();
            vg   = any_value();
            vb   = any_value();
            dl   = int'($urandom_range(0, 255));
            if (roll < 20) begin
               if ($urandom_range(0, 9) != 0) begin
                  vr = int'($urandom_range(0, 63));
                  vg = int'($urandom_range(0, 63));
                  vb = int'($urandom_range(0, 63));
               end
               queue_request(KIND_WRITE, idx, vr, vg, vb, dl);
            end else if (roll < 65) begin
               // reads only touch entries that have been written
               idx = known_list[$urandom_range(0, known_list.size() - 1)];
               queue_request(roll < 35 ? KIND_READ_RAW : KIND_READ_ADJ, idx, vr, vg, vb, dl);
            end else if (roll < 81) begin
               if ($urandom_range(0, 7) != 0) begin
                  vr = near_zero(roll < 69 || (roll >= 73 && roll < 77) ? 24 : 70);
                  vg = near_zero(roll < 69 || (roll >= 73 && roll < 77) ? 24 : 70);
                  vb = near_zero(roll < 69 || (roll >= 73 && roll < 77) ? 24 : 70);
               end
               if (roll < 69)
                  queue_request(KIND_ADD_TINT, idx, vr, vg, vb, dl);
               else if (roll < 73)
                  queue_request(KIND_SET_TINT, idx, vr, vg, vb, dl);
               else if (roll < 77)
                  queue_request(KIND_ADD_FILTER, idx, vr, vg, vb, dl);
               else
                  queue_request(KIND_SET_FILTER, idx, vr, vg, vb, dl);
            end else if (roll < 83) begin
               queue_request(KIND_CLR_FILTER, idx, vr, vg, vb, dl);
            end else if (roll < 90) begin
               if ($urandom_range(0, 7) != 0)
                  dl = int'($urandom_range(0, 6));
               queue_request(KIND_TICK, idx, vr, vg, vb, dl);
            end else if (roll < 93) begin
               if ($urandom_range(0, 5) != 0) begin
                  vr = int'($urandom_range(0, 63));
                  vg = int'($urandom_range(0, 63));
                  vb = int'($urandom_range(0, 63));
               end
               queue_request(KIND_FADE, idx, vr, vg, vb, dl);
            end else begin
               queue_request(KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                             idx, vr, vg, vb, dl);
            end
         end
         wait_for_drain();
      end

      if (error_count == 0)
         $display("[palette_tint_fade_engine_top] OK");
      else
         $display("[palette_tint_fade_engine_top] ERROR");
      $finish;
   end

endmodule
